// ----- hdl/jdc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdc_pkg
// shared constants, types and tables of the joystick direction classifier
// ----------------------------------------------------------------------------
package jdc_pkg;

  localparam int SampleBits  = 8;
  localparam int QuoW        = 15;                 // quotient bits, q <= 16384
  localparam int NumW        = SampleBits + 14;    // dividend width
  localparam int DivSteps    = QuoW;
  localparam int InW         = ((2 * SampleBits + 7) / 8) * 8;
  localparam int OutW        = 72;
  localparam int SqrtSteps   = 15;
  localparam int CordicSteps = 24;
  localparam int CordW       = 34;                 // cordic x, y and angle width

  localparam logic [SampleBits-1:0] FullScale = '1;
  localparam logic signed [CordW-1:0] PiQ30     = 34'sd3373259426;
  localparam logic signed [CordW-1:0] HalfPiQ30 = 34'sd1686629713;

  localparam logic [7:0]  CenterReset   = 8'd128;
  localparam logic [14:0] DeadzoneReset = 15'd3277;

  typedef enum logic [2:0] {
    DIR_LEFT    = 3'd0,
    DIR_RIGHT   = 3'd1,
    DIR_UP      = 3'd2,
    DIR_DOWN    = 3'd3,
    DIR_NEUTRAL = 3'd4
  } dir_e;

  typedef enum logic [1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_DEADZONE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] norm;
  } lane_out_t;

  // atan(2^-i) in units of 2^-30 rad
  function automatic logic signed [CordW-1:0] atan_q30(input int i);
    logic signed [CordW-1:0] v;
    case (i)
      0:       v = 34'sd843314856;
      1:       v = 34'sd497837829;
      2:       v = 34'sd263043836;
      3:       v = 34'sd133525158;
      4:       v = 34'sd67021686;
      5:       v = 34'sd33543515;
      6:       v = 34'sd16775850;
      7:       v = 34'sd8388437;
      8:       v = 34'sd4194282;
      9:       v = 34'sd2097149;
      10:      v = 34'sd1048575;
      11:      v = 34'sd524287;
      12:      v = 34'sd262143;
      13:      v = 34'sd131071;
      14:      v = 34'sd65535;
      15:      v = 34'sd32767;
      16:      v = 34'sd16383;
      17:      v = 34'sd8191;
      18:      v = 34'sd4095;
      19:      v = 34'sd2047;
      20:      v = 34'sd1023;
      21:      v = 34'sd511;
      22:      v = 34'sd255;
      23:      v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/jdc_norm_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdc_norm_lane
// one axis: deflection against its center, pipelined restoring divide by span
// ----------------------------------------------------------------------------
module jdc_norm_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [jdc_pkg::SampleBits-1:0]      raw_i,
  input  logic [jdc_pkg::SampleBits-1:0]      center_i,
  output jdc_pkg::lane_out_t                  lane_o
);

  localparam int SB = jdc_pkg::SampleBits;
  localparam int QW = jdc_pkg::QuoW;
  localparam int NW = jdc_pkg::NumW;
  localparam int NS = jdc_pkg::DivSteps;

  logic [NS:0]   vld_q;
  logic [SB-1:0] rem_q  [0:NS];
  logic [SB-1:0] span_q [0:NS];
  logic [QW-1:0] low_q  [0:NS];
  logic [QW-1:0] quo_q  [0:NS];
  logic [NS:0]   neg_q;

  logic [SB-1:0] rem_d  [0:NS];
  logic [QW-1:0] low_d  [0:NS];
  logic [QW-1:0] quo_d  [0:NS];

  logic          pos;
  logic          zero;
  logic [SB-1:0] dmag;
  logic [SB-1:0] span;
  logic [NW-1:0] num;

  logic               lane_vld_q;
  logic signed [15:0] lane_norm_q;
  logic signed [15:0] norm_d;

  always_comb begin
    pos  = raw_i > center_i;
    zero = raw_i == center_i;
    dmag = pos ? (raw_i - center_i) : (center_i - raw_i);
    // a zero deflection divides by one and gives zero
    span = zero ? SB'(1) : (pos ? (jdc_pkg::FullScale - center_i) : center_i);
    num  = {dmag, 14'd0} + NW'(span >> 1);
    rem_d[0] = SB'(num[NW-1:QW]);
    low_d[0] = num[QW-1:0];
    quo_d[0] = '0;
  end

  for (genvar k = 1; k <= NS; k++) begin : g_step
    logic [SB:0] t;
    logic        ge;
    always_comb begin
      t  = {rem_q[k-1], low_q[k-1][QW-1]};
      ge = t >= {1'b0, span_q[k-1]};
      rem_d[k] = ge ? SB'(t - {1'b0, span_q[k-1]}) : t[SB-1:0];
      quo_d[k] = {quo_q[k-1][QW-2:0], ge};
      low_d[k] = {low_q[k-1][QW-2:0], 1'b0};
    end
  end

  always_comb begin
    norm_d = neg_q[NS] ? -$signed({1'b0, quo_q[NS]}) : $signed({1'b0, quo_q[NS]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      lane_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q      <= {vld_q[NS-1:0], valid_i};
      lane_vld_q <= vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rem_d[0];
      low_q[0]  <= low_d[0];
      quo_q[0]  <= quo_d[0];
      span_q[0] <= span;
      neg_q[0]  <= !pos;
      for (int k = 1; k <= NS; k++) begin
        rem_q[k]  <= rem_d[k];
        low_q[k]  <= low_d[k];
        quo_q[k]  <= quo_d[k];
        span_q[k] <= span_q[k-1];
        neg_q[k]  <= neg_q[k-1];
      end
      lane_norm_q <= norm_d;
    end
  end

  assign lane_o = {lane_vld_q, lane_norm_q};

endmodule

// ----- hdl/jdc_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdc_merge
// joins both lanes: squares, pipelined root, cordic angle and direction
// ----------------------------------------------------------------------------
module jdc_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  jdc_pkg::lane_out_t  lx_i,
  input  jdc_pkg::lane_out_t  ly_i,
  input  logic [14:0]         deadzone_i,
  output logic                valid_o,
  output logic signed [15:0]  norm_x_o,
  output logic signed [15:0]  norm_y_o,
  output logic signed [15:0]  angle_o,
  output logic [14:0]         mag_o,
  output jdc_pkg::dir_e       dir_o
);

  localparam int CW = jdc_pkg::CordW;
  localparam int NC = jdc_pkg::CordicSteps;
  localparam int NQ = jdc_pkg::SqrtSteps;

  typedef struct packed {
    logic signed [15:0]   nx;
    logic signed [15:0]   ny;
    logic [14:0]          ax;
    logic [14:0]          ay;
    logic [29:0]          rem;
    logic [14:0]          root;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
  } mstage_t;

  function automatic mstage_t cordic_step(input mstage_t s, input int i);
    mstage_t r;
    r = s;
    if (s.cy > 0) begin
      r.cx = s.cx + (s.cy >>> i);
      r.cy = s.cy - (s.cx >>> i);
      r.cz = s.cz + jdc_pkg::atan_q30(i);
    end else begin
      r.cx = s.cx - (s.cy >>> i);
      r.cy = s.cy + (s.cx >>> i);
      r.cz = s.cz - jdc_pkg::atan_q30(i);
    end
    return r;
  endfunction

  // squares stage
  logic               a_vld_q;
  logic signed [15:0] a_nx_q, a_ny_q;
  logic [28:0]        a_px_q, a_py_q;
  logic signed [31:0] sqx, sqy;

  logic [NC:0] vld_q;
  mstage_t     st_q  [0:NC];
  mstage_t     st_d  [0:NC];

  // angle fix-up stage
  logic                 f_vld_q;
  logic signed [CW-1:0] f_z_q;
  logic signed [15:0]   f_nx_q, f_ny_q;
  logic [14:0]          f_ax_q, f_ay_q, f_mag_q;
  logic signed [CW-1:0] z_clamp, z_full;

  logic signed [CW-1:0] ang_sum;
  logic [15:0]          ang_mag;
  logic signed [16:0]   nx_e, ny_e, ax_e, ay_e;
  jdc_pkg::dir_e        dir_d;

  logic                 out_vld_q;
  logic signed [15:0]   out_nx_q, out_ny_q, out_ang_q;
  logic [14:0]          out_mag_q;
  jdc_pkg::dir_e        out_dir_q;

  assign sqx = lx_i.norm * lx_i.norm;
  assign sqy = ly_i.norm * ly_i.norm;

  always_comb begin
    st_d[0].nx   = a_nx_q;
    st_d[0].ny   = a_ny_q;
    st_d[0].ax   = a_nx_q[15] ? 15'(-a_nx_q) : a_nx_q[14:0];
    st_d[0].ay   = a_ny_q[15] ? 15'(-a_ny_q) : a_ny_q[14:0];
    st_d[0].rem  = 30'(a_px_q) + 30'(a_py_q);
    st_d[0].root = '0;
    st_d[0].cx   = CW'({st_d[0].ax, 16'd0});
    st_d[0].cy   = CW'({st_d[0].ay, 16'd0});
    st_d[0].cz   = '0;
  end

  for (genvar j = 0; j < NC; j++) begin : g_stage
    if (j < NQ) begin : g_root
      localparam int B = NQ - 1 - j;
      logic [30:0] trial;
      always_comb begin
        st_d[j+1] = cordic_step(st_q[j], j);
        trial = ((31'(st_q[j].root) << 1) + (31'(1) << B)) << B;
        if ({1'b0, st_q[j].rem} >= trial) begin
          st_d[j+1].rem  = 30'({1'b0, st_q[j].rem} - trial);
          st_d[j+1].root = st_q[j].root | (15'(1) << B);
        end
      end
    end else if (j == NQ) begin : g_round
      always_comb begin
        st_d[j+1] = cordic_step(st_q[j], j);
        if (st_q[j].rem > 30'(st_q[j].root)) begin
          st_d[j+1].root = st_q[j].root + 15'd1;
        end
      end
    end else begin : g_plain
      always_comb begin
        st_d[j+1] = cordic_step(st_q[j], j);
      end
    end
  end

  always_comb begin
    z_clamp = st_q[NC].cz;
    if (z_clamp < 0) begin
      z_clamp = '0;
    end
    if (z_clamp > jdc_pkg::HalfPiQ30) begin
      z_clamp = jdc_pkg::HalfPiQ30;
    end
    // exact axes bypass the cordic
    if (st_q[NC].ay == '0) begin
      z_clamp = '0;
    end else if (st_q[NC].ax == '0) begin
      z_clamp = jdc_pkg::HalfPiQ30;
    end
    z_full = st_q[NC].nx[15] ? (jdc_pkg::PiQ30 - z_clamp) : z_clamp;
  end

  always_comb begin
    ang_sum = f_z_q + CW'(65536);
    ang_mag = 16'(ang_sum >>> 17);
    nx_e = 17'(f_nx_q);
    ny_e = 17'(f_ny_q);
    ax_e = $signed({2'b00, f_ax_q});
    ay_e = $signed({2'b00, f_ay_q});
    if (f_mag_q <= deadzone_i) begin
      dir_d = jdc_pkg::DIR_NEUTRAL;
    end else if (ny_e > ax_e) begin
      dir_d = jdc_pkg::DIR_UP;
    end else if (-nx_e > ay_e) begin
      dir_d = jdc_pkg::DIR_LEFT;
    end else if (-ny_e > ax_e) begin
      dir_d = jdc_pkg::DIR_DOWN;
    end else begin
      dir_d = jdc_pkg::DIR_RIGHT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      vld_q     <= '0;
      f_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q   <= lx_i.valid;
      vld_q     <= {vld_q[NC-1:0], a_vld_q};
      f_vld_q   <= vld_q[NC];
      out_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_nx_q <= lx_i.norm;
      a_ny_q <= ly_i.norm;
      a_px_q <= sqx[28:0];
      a_py_q <= sqy[28:0];
      for (int j = 0; j <= NC; j++) begin
        st_q[j] <= st_d[j];
      end
      f_z_q   <= z_full;
      f_nx_q  <= st_q[NC].nx;
      f_ny_q  <= st_q[NC].ny;
      f_ax_q  <= st_q[NC].ax;
      f_ay_q  <= st_q[NC].ay;
      f_mag_q <= st_q[NC].root;
      out_nx_q  <= f_nx_q;
      out_ny_q  <= f_ny_q;
      out_ang_q <= f_ny_q[15] ? -$signed(ang_mag) : $signed(ang_mag);
      out_mag_q <= f_mag_q;
      out_dir_q <= dir_d;
    end
  end

  assign valid_o  = out_vld_q;
  assign norm_x_o = out_nx_q;
  assign norm_y_o = out_ny_q;
  assign angle_o  = out_ang_q;
  assign mag_o    = out_mag_q;
  assign dir_o    = out_dir_q;

endmodule

// ----- hdl/joystick_direction_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_direction_classifier
// normalizes an x/y stick sample and reports angle, magnitude and direction
// ----------------------------------------------------------------------------
// Takes one sample pair per clock when the output side does not stall and gives
// one result transaction per pair, through 1 input stage, 15 one-bit divide
// stages and an output register in each axis lane, then a squares stage, an
// absolute-value stage, 24 cordic stages (the 15-step root and its rounding
// ride along), an angle fix-up stage and the output register. A low m_axis_tready
// with m_axis_tvalid high freezes the whole pipeline. The user must write
// configuration with cfg_we_i only while no sample is in flight (not enforced).
module joystick_direction_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [jdc_pkg::InW-1:0]       s_axis_tdata,  // raw_x, raw_y, zero pad
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [jdc_pkg::OutW-1:0]      m_axis_tdata,  // norm_x, norm_y, stick_angle,
                                                       // stick_magnitude, direction_code, pad
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [14:0]                   cfg_data_i
);

  localparam int SB = jdc_pkg::SampleBits;

  logic [7:0]  center_x_q, center_y_q;
  logic [14:0] deadzone_q;
  logic        en;
  logic        accept;

  jdc_pkg::lane_out_t lx, ly;

  logic               m_valid;
  logic signed [15:0] norm_x, norm_y, angle;
  logic [14:0]        mag;
  jdc_pkg::dir_e      dir;

  assign en            = !m_valid || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= jdc_pkg::CenterReset;
      center_y_q <= jdc_pkg::CenterReset;
      deadzone_q <= jdc_pkg::DeadzoneReset;
    end else if (cfg_we_i) begin
      case (jdc_pkg::cfg_idx_e'(cfg_idx_i))
        jdc_pkg::CFG_CENTER_X: center_x_q <= cfg_data_i[7:0];
        jdc_pkg::CFG_CENTER_Y: center_y_q <= cfg_data_i[7:0];
        jdc_pkg::CFG_DEADZONE: deadzone_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  jdc_norm_lane u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (accept),
    .raw_i    (s_axis_tdata[SB-1:0]),
    .center_i (SB'(center_x_q)),
    .lane_o   (lx)
  );

  jdc_norm_lane u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (accept),
    .raw_i    (s_axis_tdata[2*SB-1:SB]),
    .center_i (SB'(center_y_q)),
    .lane_o   (ly)
  );

  jdc_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .lx_i       (lx),
    .ly_i       (ly),
    .deadzone_i (deadzone_q),
    .valid_o    (m_valid),
    .norm_x_o   (norm_x),
    .norm_y_o   (norm_y),
    .angle_o    (angle),
    .mag_o      (mag),
    .dir_o      (dir)
  );

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {6'd0, dir, mag, angle, norm_y, norm_x};

`ifndef SYNTHESIS
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lx.valid == ly.valid)
    else $error("axis lanes out of step");

  a_deadzone_neutral: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid && (mag <= deadzone_q) |-> dir == jdc_pkg::DIR_NEUTRAL)
    else $error("direction reported inside deadzone");

  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lx.valid |-> (lx.norm <= 16'sd16384) && (lx.norm >= -16'sd16384))
    else $error("normalized x out of range");

  a_stall_holds_lane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(lx.valid))
    else $error("lane moved during stall");
`endif

endmodule
